// File: src/quantized_code_dot_product_unit_macros.svh
// assertion macros for the code dot product block
`ifndef QUANTIZED_CODE_DOT_PRODUCT_UNIT_MACROS_SVH
`define QUANTIZED_CODE_DOT_PRODUCT_UNIT_MACROS_SVH

// same-cycle implication, held off during reset
`define QCDP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qcdp check failed");

// next-cycle implication, held off during reset
`define QCDP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qcdp check failed");

`endif

// File: src/qcdp_pkg.sv
// shared types, constants and codes of the code dot product block
`default_nettype none
package qcdp_pkg;

  localparam int MAX_LENGTH = 4096;
  localparam int ADDR_W     = $clog2(MAX_LENGTH);
  localparam int LEN_W      = $clog2(MAX_LENGTH + 1);
  localparam int VLEN_W     = 13;
  localparam int CW         = (LEN_W > VLEN_W) ? LEN_W : VLEN_W;
  localparam int SUM_W      = 28;
  localparam int DOC_W      = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 13;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_LENGTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_FORMAT   = CFG_IDX_W'(1);

  // code formats
  localparam logic [1:0] FMT_BYTE     = 2'd0;
  localparam logic [1:0] FMT_NIBBLE   = 2'd1;
  localparam logic [1:0] FMT_PACKED   = 2'd2;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_DOC  = 1'b1;

  typedef enum logic {ST_IDLE, ST_MAC} qcdp_state_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] code_byte;
  } qcdp_in_t;

  typedef struct packed {
    logic [SUM_W-1:0] dot_sum;
    logic [DOC_W-1:0] doc_number;
  } qcdp_out_t;

  // per-byte control from the address generator to the datapath
  typedef struct packed {
    logic pair;
    logic last;
  } qcdp_ctl_t;

endpackage
`default_nettype wire

// File: src/qcdp_qram.sv
// query code store: one write port, two registered read ports
`default_nettype none
module qcdp_qram (
  input  wire                          clk,
  input  wire                          we,
  input  wire  [qcdp_pkg::ADDR_W-1:0]  waddr,
  input  wire  [7:0]                   wdata,
  input  wire                          re,
  input  wire  [qcdp_pkg::ADDR_W-1:0]  raddr0,
  input  wire  [qcdp_pkg::ADDR_W-1:0]  raddr1,
  output logic [7:0]                   rdata0,
  output logic [7:0]                   rdata1
);
  import qcdp_pkg::*;

  logic [7:0] mem [MAX_LENGTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports
  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule
`default_nettype wire

// File: src/qcdp_addr.sv
// maps a document byte position to query store addresses and byte control
`default_nettype none
module qcdp_addr (
  input  wire  [qcdp_pkg::ADDR_W-1:0] pos,
  input  wire  [qcdp_pkg::LEN_W-1:0]  eff_len,
  input  wire                         packed_fmt,
  output logic [qcdp_pkg::ADDR_W-1:0] addr0,
  output logic [qcdp_pkg::ADDR_W-1:0] addr1,
  output qcdp_pkg::qcdp_ctl_t         ctl
);
  import qcdp_pkg::*;

  logic [LEN_W-1:0]  nbytes;
  logic [LEN_W-1:0]  full_bytes;
  logic [LEN_W-1:0]  pos_ext;
  logic [ADDR_W:0]   odd_idx;
  logic              in_full;
  logic              lone;

  // bytes per document and extent of the full 32-element blocks
  always_comb begin
    pos_ext    = LEN_W'(pos);
    nbytes     = packed_fmt ? LEN_W'((eff_len + LEN_W'(1)) >> 1) : eff_len;
    full_bytes = LEN_W'((eff_len >> 5) << 4);
    in_full    = pos_ext < full_bytes;
    odd_idx    = {pos, 1'b1};
    lone       = CW'(odd_idx) >= CW'(eff_len);
  end

  // element addresses
  always_comb begin
    if (!packed_fmt) begin
      addr0 = pos;
      addr1 = pos;
    end else if (in_full) begin
      addr0 = {pos[ADDR_W-2:4], 1'b0, pos[3:0]};
      addr1 = {pos[ADDR_W-2:4], 1'b1, pos[3:0]};
    end else begin
      addr0 = {pos[ADDR_W-2:0], 1'b0};
      addr1 = {pos[ADDR_W-2:0], 1'b1};
    end
  end

  // nibble pairing and end of document
  always_comb begin
    ctl.pair = packed_fmt && (in_full || !lone);
    ctl.last = (pos_ext + LEN_W'(1)) >= nbytes;
  end

endmodule
`default_nettype wire

// File: src/qcdp_mac.sv
// multiply-accumulate datapath with saturating running sum
`default_nettype none
module qcdp_mac (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          en,
  input  wire                          clear,
  input  qcdp_pkg::qcdp_ctl_t          ctl,
  input  wire  [7:0]                   doc_byte,
  input  wire  [7:0]                   q0,
  input  wire  [7:0]                   q1,
  output logic [qcdp_pkg::SUM_W-1:0]   sum_next
);
  import qcdp_pkg::*;

  logic [SUM_W-1:0] running_sum;
  logic [7:0]       mult0;
  logic [15:0]      prod0;
  logic [11:0]      prod1;
  logic [SUM_W:0]   total;

  // products: whole byte, or low and high nibble against two codes
  always_comb begin
    mult0 = ctl.pair ? {4'b0, doc_byte[3:0]} : doc_byte;
    prod0 = q0 * mult0;
    prod1 = ctl.pair ? (q1 * doc_byte[7:4]) : 12'd0;
    total = (SUM_W + 1)'(running_sum) + (SUM_W + 1)'(prod0) + (SUM_W + 1)'(prod1);
    sum_next = total[SUM_W] ? {SUM_W{1'b1}} : total[SUM_W-1:0];
  end

  // accumulator, cleared at end of document or on a write to a mapped register
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      running_sum <= '0;
    end else if (en) begin
      running_sum <= ctl.last ? '0 : sum_next;
    end
  end

endmodule
`default_nettype wire

// File: src/quantized_code_dot_product_unit.sv
// code dot product block: one query store, streaming document accumulation
// a query load does not raise busy; a document byte keeps busy high for one cycle
// and passes through the store read and then the accumulate. the result strobe is
// registered from the accumulate state, is one cycle wide, and cannot be stalled.
// synchronous reset clears positions, sum, document count and registers (length 32,
// eight-bit codes); store is not cleared.
`default_nettype none
module quantized_code_dot_product_unit (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              start,
  output logic                             busy,
  input  qcdp_pkg::qcdp_in_t               item,
  output logic                             done,
  output qcdp_pkg::qcdp_out_t              result,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [qcdp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [qcdp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import qcdp_pkg::*;

  qcdp_state_t       state, state_next;
  logic [VLEN_W-1:0] vector_length;
  logic [1:0]        code_format;
  logic [ADDR_W-1:0] fill_pos;
  logic [ADDR_W-1:0] doc_pos;
  logic [DOC_W-1:0]  doc_counter;
  qcdp_ctl_t         ctl, ctl_q;
  logic [7:0]        byte_q;
  logic [LEN_W-1:0]  eff_len;
  logic [ADDR_W-1:0] addr0, addr1;
  logic [7:0]        q0, q1;
  logic [SUM_W-1:0]  sum_next;
  logic              accept, load_req, doc_req, cfg_wr, mac_en, packed_fmt;

  assign cfg_ready  = 1'b1;
  assign cfg_wr     = cfg_valid && cfg_ready;
  assign accept     = start && !busy;
  assign load_req   = accept && (item.mode == MODE_LOAD);
  assign doc_req    = accept && (item.mode == MODE_DOC);
  assign packed_fmt = (code_format == FMT_PACKED);

  // effective length, clamped to one through the store depth
  always_comb begin
    if (vector_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (CW'(vector_length) > CW'(MAX_LENGTH)) begin
      eff_len = LEN_W'(MAX_LENGTH);
    end else begin
      eff_len = LEN_W'(vector_length);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (doc_req) state_next = ST_MAC;
      ST_MAC:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy   = 1'b0;
    mac_en = 1'b0;
    unique case (state)
      ST_IDLE: ;
      ST_MAC: begin
        busy   = 1'b1;
        mac_en = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length <= VLEN_W'(32);
      code_format   <= FMT_BYTE;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_VECTOR_LENGTH: vector_length <= cfg_data[VLEN_W-1:0];
        CFG_CODE_FORMAT:   code_format   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic cfg_clear;
  assign cfg_clear = cfg_wr &&
                     (cfg_index == CFG_VECTOR_LENGTH || cfg_index == CFG_CODE_FORMAT);

  // query fill position, wraps after the last element
  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      fill_pos <= '0;
    end else if (load_req) begin
      if ((LEN_W'(fill_pos) + LEN_W'(1)) >= eff_len) begin
        fill_pos <= '0;
      end else begin
        fill_pos <= fill_pos + ADDR_W'(1);
      end
    end
  end

  // document byte position
  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      doc_pos <= '0;
    end else if (doc_req) begin
      doc_pos <= ctl.last ? '0 : doc_pos + ADDR_W'(1);
    end
  end

  // byte and control held for the accumulate cycle
  always_ff @(posedge clk) begin
    if (doc_req) begin
      ctl_q  <= ctl;
      byte_q <= item.code_byte;
    end
  end

  // result and document count
  always_ff @(posedge clk) begin
    if (rst) begin
      done        <= 1'b0;
      doc_counter <= '0;
    end else begin
      done <= mac_en && ctl_q.last;
      if (mac_en && ctl_q.last) begin
        doc_counter <= doc_counter + DOC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mac_en && ctl_q.last) begin
      result.dot_sum    <= sum_next;
      result.doc_number <= doc_counter;
    end
  end

  qcdp_addr u_addr (
    .pos        (doc_pos),
    .eff_len    (eff_len),
    .packed_fmt (packed_fmt),
    .addr0      (addr0),
    .addr1      (addr1),
    .ctl        (ctl)
  );

  qcdp_qram u_qram (
    .clk    (clk),
    .we     (load_req),
    .waddr  (fill_pos),
    .wdata  (item.code_byte),
    .re     (doc_req),
    .raddr0 (addr0),
    .raddr1 (addr1),
    .rdata0 (q0),
    .rdata1 (q1)
  );

  qcdp_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .en       (mac_en),
    .clear    (cfg_clear),
    .ctl      (ctl_q),
    .doc_byte (byte_q),
    .q0       (q0),
    .q1       (q1),
    .sum_next (sum_next)
  );

endmodule
`default_nettype wire

// File: src/qcdp_checker.sv
// port-level checks of request and result timing, bound to the top level
`default_nettype none
`include "quantized_code_dot_product_unit_macros.svh"
module qcdp_checker (
  input wire                clk,
  input wire                rst,
  input wire                start,
  input wire                busy,
  input qcdp_pkg::qcdp_in_t item,
  input wire                done
);
  import qcdp_pkg::*;

  // a document byte request occupies the block for the next cycle
  `QCDP_ASSERT_NEXT(a_doc_busy, start && !busy && item.mode == MODE_DOC, busy)

  // a query load neither stalls the block nor yields a result
  `QCDP_ASSERT_NEXT(a_load_quiet, start && !busy && item.mode == MODE_LOAD, !busy && !done)

  // busy drops once the accumulate state is done
  `QCDP_ASSERT_NEXT(a_busy_once, busy, !busy)

  // a result is a one-cycle strobe while the block is free
  `QCDP_ASSERT_NOW(a_done_idle, done, !busy)

endmodule

bind quantized_code_dot_product_unit qcdp_checker u_qcdp_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .item  (item),
  .done  (done)
);
`default_nettype wire

// File: dv/qcdp_tracker_pkg.sv
// dot product predictor and result checker for the code dot product testbench
package qcdp_tracker_pkg;
  import qcdp_pkg::*;

  localparam int unsigned SUM_LIMIT = (1 << SUM_W) - 1;

  class dot_sum_tracker;
    logic [7:0]       query_codes [MAX_LENGTH];
    bit               code_written [MAX_LENGTH];
    logic [VLEN_W-1:0] len_reg;
    logic [1:0]       fmt_reg;
    int unsigned      fill_pos;
    int unsigned      byte_pos;
    int unsigned      acc;
    logic [DOC_W-1:0] doc_count;
    qcdp_out_t        pending_sums [$];
    int unsigned      sums_predicted;
    int unsigned      sums_checked;
    int unsigned      failures;

    function new();
      len_reg        = VLEN_W'(32);
      fmt_reg        = FMT_BYTE;
      fill_pos       = 0;
      byte_pos       = 0;
      acc            = 0;
      doc_count      = '0;
      sums_predicted = 0;
      sums_checked   = 0;
      failures       = 0;
      foreach (code_written[i]) code_written[i] = 1'b0;
    endfunction

    // zero acts as one, anything above the store depth acts as the depth
    function int unsigned active_length();
      if (len_reg == 0) return 1;
      if (len_reg > MAX_LENGTH) return MAX_LENGTH;
      return len_reg;
    endfunction

    function int unsigned doc_bytes();
      return (fmt_reg == FMT_PACKED) ? (active_length() + 1) >> 1 : active_length();
    endfunction

    // true once every query entry a document of n elements reads is written
    function bit query_ready(int unsigned n);
      for (int unsigned i = 0; i < n; i++) begin
        if (!code_written[i]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function int unsigned code_at(int unsigned idx);
      return (idx < MAX_LENGTH) ? int'(query_codes[idx]) : 0;
    endfunction

    // contribution of one document byte at byte position pos
    function int unsigned byte_weight(int unsigned pos, logic [7:0] b, int unsigned n);
      int unsigned full_bytes;
      int unsigned k;
      int unsigned base;
      if (fmt_reg != FMT_PACKED) return code_at(pos) * b;
      full_bytes = (n >> 5) * 16;
      // full 32-element block: element j low nibble, element j+16 high nibble
      if (pos < full_bytes) begin
        base = (pos / 16) * 32 + (pos % 16);
        return code_at(base) * b[3:0] + code_at(base + 16) * b[7:4];
      end
      // remainder: adjacent pairs, then a lone element using the whole byte
      k    = pos - full_bytes;
      base = (n & ~32'h1F) + 2 * k;
      if (k < ((n & 32'h1F) >> 1)) return code_at(base) * b[3:0] + code_at(base + 1) * b[7:4];
      return code_at(base) * b;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_VECTOR_LENGTH) begin
        len_reg = value[VLEN_W-1:0];
      end else if (idx == CFG_CODE_FORMAT) begin
        fmt_reg = value[1:0];
      end else begin
        return;
      end
      // any mapped write drops query fill and the document in progress
      fill_pos = 0;
      byte_pos = 0;
      acc      = 0;
    endfunction

    // one accepted request: query load or document byte
    function void take_request(qcdp_in_t req);
      int unsigned n;
      qcdp_out_t   sum;
      n = active_length();
      if (req.mode == MODE_LOAD) begin
        if (fill_pos < MAX_LENGTH) begin
          query_codes[fill_pos]  = req.code_byte;
          code_written[fill_pos] = 1'b1;
        end
        fill_pos++;
        if (fill_pos >= n) fill_pos = 0;
        return;
      end
      acc += byte_weight(byte_pos, req.code_byte, n);
      if (acc > SUM_LIMIT) acc = SUM_LIMIT;
      byte_pos++;
      if (byte_pos < doc_bytes()) return;
      sum.dot_sum    = SUM_W'(acc);
      sum.doc_number = doc_count;
      pending_sums.push_back(sum);
      sums_predicted++;
      doc_count++;
      byte_pos = 0;
      acc      = 0;
    endfunction

    function void note_failure(string what);
      if (failures < 10) $display("mismatch: %s", what);
      failures++;
    endfunction

    function void check_sum(qcdp_out_t got);
      qcdp_out_t want;
      sums_checked++;
      if (pending_sums.size() == 0) begin
        note_failure($sformatf("unexpected result: dot_sum %0d doc_number %0d",
                               got.dot_sum, got.doc_number));
        return;
      end
      want = pending_sums.pop_front();
      if (got.dot_sum !== want.dot_sum)
        note_failure($sformatf("doc %0d dot_sum: expected %0d, got %0d",
                               want.doc_number, want.dot_sum, got.dot_sum));
      if (got.doc_number !== want.doc_number)
        note_failure($sformatf("doc_number: expected %0d, got %0d",
                               want.doc_number, got.doc_number));
    endfunction
  endclass

endpackage

// File: dv/tb_top.sv
// top-level testbench for the code dot product block
module tb_top;
  import qcdp_pkg::*;
  import qcdp_tracker_pkg::*;

  localparam logic [1:0]           FMT_UNUSED        = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LOW  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HIGH = {CFG_IDX_W{1'b1}};
  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_CYCLES  = 10;
  localparam int RANDOM_GOAL   = 1300;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  start     = 1'b0;
  logic                  busy;
  qcdp_in_t              item      = '0;
  logic                  done;
  qcdp_out_t             result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  dot_sum_tracker tracker;
  int unsigned    items_sent = 0;
  int unsigned    reg_writes = 0;
  int             burst_left = 0;

  quantized_code_dot_product_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // results cannot be held off: check every strobe
  always @(posedge clk) begin
    if (!rst && done === 1'b1) tracker.check_sum(result);
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one request; sender runs in bursts with random gaps between them
  task automatic send_request(input logic m, input logic [7:0] code);
    int       gap;
    qcdp_in_t req;
    req.mode      = m;
    req.code_byte = code;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    item  <= req;
    do @(posedge clk); while (busy !== 1'b0);
    tracker.take_request(req);
    items_sent++;
  endtask

  // register write once all sums are out and the block has settled
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    start <= 1'b0;
    while (tracker.pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    tracker.set_register(idx, value);
    reg_writes++;
  endtask

  task automatic load_query(input int unsigned count);
    repeat (count) send_request(MODE_LOAD, pick_byte());
  endtask

  // document bytes, with stray query loads mixed in when noisy
  task automatic send_doc(input int unsigned count, input bit noisy);
    repeat (count) begin
      if (noisy && $urandom_range(0, 19) == 0) send_request(MODE_LOAD, pick_byte());
      send_request(MODE_DOC, pick_byte());
    end
  endtask

  task automatic run_phase(input int unsigned len, input logic [1:0] fmt,
                           input int unsigned docs);
    int unsigned n;
    if ($urandom_range(0, 1)) begin
      write_register(CFG_VECTOR_LENGTH, CFG_DATA_W'(len));
      write_register(CFG_CODE_FORMAT, CFG_DATA_W'(fmt));
    end else begin
      write_register(CFG_CODE_FORMAT, CFG_DATA_W'(fmt));
      write_register(CFG_VECTOR_LENGTH, CFG_DATA_W'(len));
    end
    n = tracker.active_length();
    if (!tracker.query_ready(n)) load_query(n);
    else load_query($urandom_range(0, (n < 40) ? n : 40));
    repeat (docs) send_doc(tracker.doc_bytes(), 1'b1);
    // sometimes leave a document unfinished for the next write to drop
    if ($urandom_range(0, 5) == 0 && tracker.doc_bytes() > 1)
      send_doc($urandom_range(1, tracker.doc_bytes() - 1), 1'b1);
  endtask

  initial begin
    int unsigned goal;
    int unsigned len;
    int unsigned waited;
    tracker = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: length 32, eight-bit codes
    load_query(32);
    send_doc(32, 1'b0);
    send_doc(32, 1'b1);

    // length zero acts as one
    write_register(CFG_VECTOR_LENGTH, CFG_DATA_W'(0));
    write_register(CFG_CODE_FORMAT, CFG_DATA_W'(FMT_BYTE));
    send_request(MODE_LOAD, 8'hFF);
    send_request(MODE_DOC, 8'hFF);
    send_request(MODE_DOC, 8'h00);

    // unused format code behaves as eight-bit; third load wraps onto entry 0
    write_register(CFG_CODE_FORMAT, CFG_DATA_W'(FMT_UNUSED));
    write_register(CFG_VECTOR_LENGTH, CFG_DATA_W'(2));
    send_request(MODE_LOAD, 8'hFF);
    send_request(MODE_LOAD, 8'h01);
    send_request(MODE_LOAD, 8'h80);
    send_request(MODE_DOC, 8'hFF);
    send_request(MODE_DOC, 8'hFF);

    // unpacked four-bit with full-byte codes on both sides
    write_register(CFG_CODE_FORMAT, CFG_DATA_W'(FMT_NIBBLE));
    write_register(CFG_VECTOR_LENGTH, CFG_DATA_W'(1));
    send_request(MODE_LOAD, 8'hFF);
    send_request(MODE_DOC, 8'hFF);

    // packed pair then lone last element; a load lands mid-document
    write_register(CFG_CODE_FORMAT, CFG_DATA_W'(FMT_PACKED));
    write_register(CFG_VECTOR_LENGTH, CFG_DATA_W'(3));
    send_request(MODE_LOAD, 8'hFF);
    send_request(MODE_LOAD, 8'hFF);
    send_request(MODE_LOAD, 8'hFF);
    send_request(MODE_DOC, 8'hFF);
    send_request(MODE_LOAD, 8'h11);
    send_request(MODE_DOC, 8'hFF);

    // partial document dropped by a register write
    write_register(CFG_CODE_FORMAT, CFG_DATA_W'(FMT_BYTE));
    send_request(MODE_DOC, 8'h5A);
    write_register(CFG_CODE_FORMAT, CFG_DATA_W'(FMT_BYTE));
    send_doc(3, 1'b0);

    // writes to unmapped indexes change nothing
    write_register(CFG_UNMAPPED_LOW, {CFG_DATA_W{1'b1}});
    write_register(CFG_UNMAPPED_HIGH, {CFG_DATA_W{1'b1}});
    send_doc(3, 1'b0);

    // random phases, mostly short vectors
    goal = RANDOM_GOAL;
    while (items_sent < goal) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: len = $urandom_range(1, 40);
        6, 7:             len = $urandom_range(41, 200);
        8:                len = $urandom_range(0, 3);
        default:          len = 32 * $urandom_range(1, 4) + $urandom_range(0, 1);
      endcase
      run_phase(len, 2'($urandom_range(0, 3)), $urandom_range(1, 5));
    end

    // drain
    start <= 1'b0;
    waited = 0;
    while (tracker.pending_sums.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.pending_sums.size() != 0)
      tracker.note_failure($sformatf("%0d dot products never arrived",
                                     tracker.pending_sums.size()));

    $display("checked %0d dot products from %0d requests and %0d register writes",
             tracker.sums_checked, items_sent, reg_writes);
    $display("lengths 0 to 200, all four format codes, stray loads, dropped documents");
    if (tracker.failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", tracker.failures);
      $display("Verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/qcdp_pkg.sv
src/qcdp_qram.sv
src/qcdp_addr.sv
src/qcdp_mac.sv
src/quantized_code_dot_product_unit.sv
src/qcdp_checker.sv
dv/qcdp_tracker_pkg.sv
dv/tb_top.sv
